### hdl/qvr_pkg.sv
package qvr_pkg;

	localparam int QUAT_WIDTH = 16;
	localparam int SAMPLE_WIDTH_DEF = 16;
	// |q|^2 of four 16-bit squares
	localparam int NORM_WIDTH = 2 * QUAT_WIDTH + 2;
	// rotation matrix entries, signed
	localparam int MAT_WIDTH = 2 * QUAT_WIDTH + 3;

endpackage

### hdl/qvr_divider.sv
module qvr_divider #(
	parameter int NUM_WIDTH = 70,
	parameter int DEN_WIDTH = 34,
	parameter int QUO_WIDTH = 17
) (
	input  logic                        clk,
	input  logic                        advance,
	input  logic signed [NUM_WIDTH-1:0] num,
	input  logic        [DEN_WIDTH-1:0] den,
	output logic signed [QUO_WIDTH-1:0] quo
);

	// one quotient bit per stage, restoring division of the magnitude
	localparam int RW = DEN_WIDTH + 1;
	localparam int NS = QUO_WIDTH + 1;

	logic [NUM_WIDTH-1:0] mag_s [NS+1];
	logic [RW-1:0]        rem_s [NS+1];
	logic [NS-1:0]        qb_s  [NS+1];
	logic [DEN_WIDTH-1:0] den_s [NS+1];
	logic                 neg_s [NS+1];
	logic signed [QUO_WIDTH-1:0] quo_q;

	logic [NUM_WIDTH-1:0] abs_num;
	// magnitude of num*2 + den rounded: floor((2|a|+d)/(2d)) gives half-up for
	// positive; negative handled via floor((2a+d)/(2d)) on signed value
	logic signed [NUM_WIDTH+1:0] adj;

	always_comb begin
		adj = (NUM_WIDTH+2)'(num) * 2 + (NUM_WIDTH+2)'($signed({1'b0, den}));
		abs_num = adj[NUM_WIDTH+1] ? NUM_WIDTH'(-adj) : NUM_WIDTH'(adj);
	end

	// stage 0 registers the operands
	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s[0] <= abs_num;
			rem_s[0] <= '0;
			qb_s[0]  <= '0;
			den_s[0] <= den;
			neg_s[0] <= adj[NUM_WIDTH+1];
		end
	end

	// quotient of adj / (2 den) fits in NS bits; the high bits of the
	// magnitude stay below the divisor, so start from bit NS-1 of the shifted word
	for (genvar i = 0; i < NS; i++) begin : g_step
		logic [RW:0]  trial;
		logic [RW-1:0] nrem;
		logic          bitq;
		logic [NUM_WIDTH-1:0] m;
		always_comb begin
			m = mag_s[i];
			if (i == 0)
				trial = {1'b0, (RW)'(m >> (NS))} << 1 | (RW+1)'(m[NS-1]);
			else
				trial = {rem_s[i], m[NS-1-i]};
			bitq = trial >= {1'b0, den_s[i], 1'b0};
			nrem = bitq ? RW'(trial - {1'b0, den_s[i], 1'b0}) : RW'(trial);
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				mag_s[i+1] <= mag_s[i];
				rem_s[i+1] <= nrem;
				qb_s[i+1]  <= {qb_s[i][NS-2:0], bitq};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	logic [NS-1:0] qm;
	logic          rz;
	always_comb begin
		qm = qb_s[NS];
		rz = rem_s[NS] == '0;
	end

	// floor for negatives: -ceil(|a|/d)
	always_ff @(posedge clk) begin
		if (advance) begin
			if (neg_s[NS])
				quo_q <= QUO_WIDTH'(-$signed({1'b0, qm}) - (rz ? 0 : 1));
			else
				quo_q <= QUO_WIDTH'(qm);
		end
	end

	assign quo = quo_q;

endmodule

### hdl/quaternion_vector_rotation_core.sv
// channel | valid  | stall  | word fields
// in      | valid  | stall  | quat_w..z, body_accel_x/y/z
// out     | ovalid | ostall | world_accel_x/y/z, zero_quat
// one word per cycle while ostall does not freeze the pipeline; a word
// accepted at the input passes four multiply and add stages, the divider
// operand register, one divider stage per quotient bit (SAMPLE_WIDTH + 2)
// and the quotient register.
// reset clears only the valid bits. a stall on the output freezes the whole
// pipeline, so stall on the input follows ostall while the last stage is full.
module quaternion_vector_rotation_core #(
	parameter int SAMPLE_WIDTH = qvr_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        stall,
	input  logic signed [15:0]          quat_w,
	input  logic signed [15:0]          quat_x,
	input  logic signed [15:0]          quat_y,
	input  logic signed [15:0]          quat_z,
	input  logic signed [SAMPLE_WIDTH-1:0] body_accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] body_accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] body_accel_z,
	output logic                        ovalid,
	input  logic                        ostall,
	output logic signed [SAMPLE_WIDTH:0] world_accel_x,
	output logic signed [SAMPLE_WIDTH:0] world_accel_y,
	output logic signed [SAMPLE_WIDTH:0] world_accel_z,
	output logic                        zero_quat
);

	localparam int QW = qvr_pkg::QUAT_WIDTH;
	localparam int NW = qvr_pkg::NORM_WIDTH;
	localparam int MW = qvr_pkg::MAT_WIDTH;
	localparam int PW = 2 * QW + 1;
	localparam int SW = SAMPLE_WIDTH;
	localparam int OW = SW + 1;
	localparam int DW = MW + SW + 2;
	localparam int DLAT = OW + 3;
	localparam int LAT = 4 + DLAT;

	logic adv;
	logic [LAT-1:0] vld_q;

	assign adv = !(vld_q[LAT-1] && ostall);
	assign stall = !adv;
	assign ovalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], valid};
		end
	end

	// stage 1: products of quaternion parts
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [SW-1:0] v_s1 [3];
	logic                 zq_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= PW'(quat_w * quat_w);
			xx_s1 <= PW'(quat_x * quat_x);
			yy_s1 <= PW'(quat_y * quat_y);
			zz_s1 <= PW'(quat_z * quat_z);
			xy_s1 <= PW'(quat_x * quat_y);
			wz_s1 <= PW'(quat_w * quat_z);
			xz_s1 <= PW'(quat_x * quat_z);
			wy_s1 <= PW'(quat_w * quat_y);
			yz_s1 <= PW'(quat_y * quat_z);
			wx_s1 <= PW'(quat_w * quat_x);
			v_s1[0] <= body_accel_x;
			v_s1[1] <= body_accel_y;
			v_s1[2] <= body_accel_z;
			zq_s1 <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
		end
	end

	// stage 2: matrix entries and norm
	logic signed [MW-1:0] m_s2 [3][3];
	logic        [NW-1:0] n_s2;
	logic signed [SW-1:0] v_s2 [3];
	logic                 zq_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0][0] <= MW'(ww_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
			m_s2[0][1] <= (MW'(xy_s1) - MW'(wz_s1)) <<< 1;
			m_s2[0][2] <= (MW'(xz_s1) + MW'(wy_s1)) <<< 1;
			m_s2[1][0] <= (MW'(xy_s1) + MW'(wz_s1)) <<< 1;
			m_s2[1][1] <= MW'(ww_s1) - MW'(xx_s1) + MW'(yy_s1) - MW'(zz_s1);
			m_s2[1][2] <= (MW'(yz_s1) - MW'(wx_s1)) <<< 1;
			m_s2[2][0] <= (MW'(xz_s1) - MW'(wy_s1)) <<< 1;
			m_s2[2][1] <= (MW'(yz_s1) + MW'(wx_s1)) <<< 1;
			m_s2[2][2] <= MW'(ww_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
			n_s2 <= NW'(ww_s1) + NW'(xx_s1) + NW'(yy_s1) + NW'(zz_s1);
			v_s2 <= v_s1;
			zq_s2 <= zq_s1;
		end
	end

	// stage 3: row products; stage 4: row sums
	logic signed [MW+SW-1:0] p_s3 [3][3];
	logic        [NW-1:0]    n_s3, n_s4;
	logic                    zq_s3;
	logic signed [DW-1:0]    s_s4 [3];
	logic [DLAT:0]           zq_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					p_s3[r][c] <= (MW+SW)'(m_s2[r][c] * v_s2[c]);
			n_s3 <= n_s2;
			zq_s3 <= zq_s2;
			for (int r = 0; r < 3; r++)
				s_s4[r] <= DW'(p_s3[r][0]) + DW'(p_s3[r][1]) + DW'(p_s3[r][2]);
			n_s4 <= n_s3;
			zq_d <= {zq_d[DLAT-1:0], zq_s3};
		end
	end

	logic signed [OW-1:0] quo [3];
	logic [NW-1:0] den;
	assign den = (n_s4 == '0) ? NW'(1) : n_s4;

	for (genvar r = 0; r < 3; r++) begin : g_div
		qvr_divider #(
			.NUM_WIDTH(DW),
			.DEN_WIDTH(NW),
			.QUO_WIDTH(OW)
		) u_div (
			.clk   (clk),
			.advance(adv),
			.num   (s_s4[r]),
			.den   (den),
			.quo   (quo[r])
		);
	end

	logic zq_out;
	assign zq_out = zq_d[DLAT];

	assign world_accel_x = zq_out ? '0 : quo[0];
	assign world_accel_y = zq_out ? '0 : quo[1];
	assign world_accel_z = zq_out ? '0 : quo[2];
	assign zero_quat = zq_out;

endmodule
